// ===== sv/htb_pkg.sv =====
// Shared types, constants and helper functions for the hex text to bytes parser.
package htb_pkg;

    localparam logic [15:0] SAT_LIMIT  = 16'hFFFF;
    localparam int          FIFO_DEPTH = 4;
    localparam int          FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int          FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [5:0] {
        PH_START    = 6'b000001,
        PH_HIGH     = 6'b000010,
        PH_LOW      = 6'b000100,
        PH_AFTER_SP = 6'b001000,
        PH_AFTER_CR = 6'b010000,
        PH_DROP     = 6'b100000
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  byte_value;
        logic [15:0] number;
        logic        last;
    } t_result;

    // Up to two results per character, in order r0 then r1.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v != SAT_LIMIT) ? v + 16'd1 : v;
    endfunction

    // Bit 4 set: not a hex digit. Lowercase accepted.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c inside {[8'd48:8'd57]}) begin
            r = {1'b0, 4'(c - 8'd48)};
        end else if (c inside {[8'd65:8'd70]}) begin
            r = {1'b0, 4'(c - 8'd55)};
        end else if (c inside {[8'd97:8'd102]}) begin
            r = {1'b0, 4'(c - 8'd87)};
        end
        return r;
    endfunction

endpackage

// ===== sv/hex_text_to_bytes_parser_unit.sv =====
// The character is first held in the input register, then its results are written into the
// result queue, from which they show at the output ports.
// Throughput: one character per cycle while the result queue has room for two; a character
// that ends a string after a good pair yields two results, which leave the queue in turn.
// The input register advances only when the result queue has room for two results.
// Reset: synchronous, active low; clears the parser state and empties the queue.
module hex_text_to_bytes_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_byte_value,
    output logic [15:0] o_number,
    output logic        o_last
);
    import htb_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       core_fire;
    logic       space2;
    t_push      push;
    t_result    head;

    assign core_fire  = r_in_valid && space2;
    assign o_in_ready = !r_in_valid || core_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_char <= i_char_code;
        end
    end

    htb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (core_fire),
        .i_char  (r_in_char),
        .o_push  (push)
    );

    htb_out_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space2 (space2),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_data   (head)
    );

    assign o_kind       = head.kind;
    assign o_byte_value = head.byte_value;
    assign o_number     = head.number;
    assign o_last       = head.last;

endmodule

// ===== sv/htb_core.sv =====
// Parser state registers and combinational per-character update logic.
module htb_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [7:0]    i_char,
    output htb_pkg::t_push o_push
);
    import htb_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_high, n_high;
    logic [7:0]  r_low, n_low;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_pair_pos, n_pair_pos;
    logic [15:0] r_count, n_count;

    logic        go_start;
    logic        do_clear;
    logic [4:0]  hv;
    logic [4:0]  lv;
    logic        sep;
    logic [15:0] cnt_inc;

    always_comb begin
        n_phase    = r_phase;
        n_high     = r_high;
        n_low      = r_low;
        n_pos      = r_pos;
        n_pair_pos = r_pair_pos;
        n_count    = r_count;
        o_push     = '0;
        go_start   = 1'b0;
        do_clear   = 1'b0;
        hv         = hex_digit(r_high);
        lv         = hex_digit(r_low);
        sep        = i_char inside {CH_SP, CH_NUL, CH_CR};
        cnt_inc    = sat_inc(r_count);

        if (i_fire) begin
            case (r_phase)
                PH_AFTER_SP: begin
                    if (i_char == CH_CR) begin
                        n_phase = PH_AFTER_CR;
                        n_pos   = sat_inc(r_pos);
                    end else if (i_char == CH_LF) begin
                        n_phase = PH_START;
                        n_pos   = sat_inc(r_pos);
                    end else begin
                        go_start = 1'b1;
                    end
                end
                PH_AFTER_CR: begin
                    if (i_char == CH_LF) begin
                        n_phase = PH_START;
                        n_pos   = sat_inc(r_pos);
                    end else begin
                        go_start = 1'b1;
                    end
                end
                PH_START: go_start = 1'b1;
                PH_HIGH: begin
                    if (i_char == CH_NUL) begin
                        o_push.count = 2'd1;
                        o_push.r0    = '{kind: KIND_ERROR, byte_value: 8'd0,
                                         number: r_pair_pos, last: 1'b1};
                        do_clear     = 1'b1;
                    end else begin
                        n_low   = i_char;
                        n_phase = PH_LOW;
                        n_pos   = sat_inc(r_pos);
                    end
                end
                PH_LOW: begin
                    if (sep && !hv[4] && !lv[4]) begin
                        n_count   = cnt_inc;
                        o_push.r0 = '{kind: KIND_BYTE, byte_value: {hv[3:0], lv[3:0]},
                                      number: 16'd0, last: 1'b1};
                        if (i_char == CH_NUL) begin
                            // byte, then done with the updated count
                            o_push.count   = 2'd2;
                            o_push.r0.last = 1'b0;
                            o_push.r1      = '{kind: KIND_DONE, byte_value: 8'd0,
                                               number: cnt_inc, last: 1'b1};
                            do_clear       = 1'b1;
                        end else begin
                            o_push.count = 2'd1;
                            n_phase = (i_char == CH_SP) ? PH_AFTER_SP : PH_AFTER_CR;
                            n_pos   = sat_inc(r_pos);
                        end
                    end else begin
                        o_push.count = 2'd1;
                        o_push.r0    = '{kind: KIND_ERROR, byte_value: 8'd0,
                                         number: r_pair_pos, last: 1'b1};
                        if (i_char == CH_NUL) begin
                            do_clear = 1'b1;
                        end else begin
                            n_phase = PH_DROP;
                            n_pos   = sat_inc(r_pos);
                        end
                    end
                end
                PH_DROP: begin
                    if (i_char == CH_NUL) begin
                        do_clear = 1'b1;
                    end else begin
                        n_pos = sat_inc(r_pos);
                    end
                end
                default: go_start = 1'b1;
            endcase

            if (go_start) begin
                if (i_char == CH_NUL) begin
                    o_push.count = 2'd1;
                    o_push.r0    = '{kind: KIND_DONE, byte_value: 8'd0,
                                     number: r_count, last: 1'b1};
                    do_clear     = 1'b1;
                end else begin
                    n_high     = i_char;
                    n_pair_pos = r_pos;
                    n_phase    = PH_HIGH;
                    n_pos      = sat_inc(r_pos);
                end
            end

            if (do_clear) begin
                n_phase    = PH_START;
                n_high     = 8'd0;
                n_low      = 8'd0;
                n_pos      = 16'd0;
                n_pair_pos = 16'd0;
                n_count    = 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_high     <= 8'd0;
            r_low      <= 8'd0;
            r_pos      <= 16'd0;
            r_pair_pos <= 16'd0;
            r_count    <= 16'd0;
        end else begin
            r_phase    <= n_phase;
            r_high     <= n_high;
            r_low      <= n_low;
            r_pos      <= n_pos;
            r_pair_pos <= n_pair_pos;
            r_count    <= n_count;
        end
    end

endmodule

// ===== sv/htb_out_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle while i_ready is high.
module htb_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  htb_pkg::t_push   i_push,
    output logic             o_space2,
    output logic             o_valid,
    input  logic             i_ready,
    output htb_pkg::t_result o_data
);
    import htb_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, n_wr;
    logic [FIFO_AW-1:0]   r_rd, n_rd;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic                 pop;

    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rd];
    assign o_space2 = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign pop      = o_valid && i_ready;

    always_comb begin
        n_wr    = r_wr + FIFO_AW'(i_push.count);
        n_rd    = r_rd + FIFO_AW'(pop);
        n_count = r_count + FIFO_CW'(i_push.count) - FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + FIFO_AW'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the hex text to bytes parser: streams text and checks every result.
`timescale 1ns / 1ps

module tb;
    import htb_pkg::*;

    class hex_parse_checker;
        t_phase      phase;
        logic [7:0]  high_ch;
        logic [7:0]  low_ch;
        logic [15:0] char_pos;
        logic [15:0] pair_pos;
        logic [15:0] byte_total;
        t_result     awaited[$];
        int unsigned errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase      = PH_START;
            high_ch    = '0;
            low_ch     = '0;
            char_pos   = '0;
            pair_pos   = '0;
            byte_total = '0;
        endfunction

        function logic [15:0] bump(input logic [15:0] v);
            return (v == SAT_LIMIT) ? v : v + 16'd1;
        endfunction

        // Bit 4 flags a character that is not a hex digit.
        function logic [4:0] nibble_of(input logic [7:0] c);
            logic [7:0] lc;
            lc = c | 8'h20;
            if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
            if (lc >= "a" && lc <= "f") return {1'b0, lc[3:0] + 4'd9};
            return 5'h10;
        endfunction

        function t_result make_result(input t_kind k, input logic [7:0] b,
                                      input logic [15:0] num);
            t_result r;
            r.kind       = k;
            r.byte_value = b;
            r.number     = num;
            r.last       = 1'b0;
            return r;
        endfunction

        function void take_char(input logic [7:0] c);
            t_result    res[2];
            int         n;
            t_phase     p;
            logic [4:0] hv;
            logic [4:0] lv;
            n = 0;
            p = phase;
            if (p == PH_AFTER_SP) begin
                if (c == CH_CR) begin
                    phase    = PH_AFTER_CR;
                    char_pos = bump(char_pos);
                    return;
                end
                if (c == CH_LF) begin
                    phase    = PH_START;
                    char_pos = bump(char_pos);
                    return;
                end
                p = PH_START;
            end
            if (p == PH_AFTER_CR) begin
                if (c == CH_LF) begin
                    phase    = PH_START;
                    char_pos = bump(char_pos);
                    return;
                end
                p = PH_START;
            end
            case (p)
                PH_START: begin
                    if (c == CH_NUL) begin
                        res[n++] = make_result(KIND_DONE, 8'h00, byte_total);
                        restart();
                    end else begin
                        high_ch  = c;
                        pair_pos = char_pos;
                        phase    = PH_HIGH;
                        char_pos = bump(char_pos);
                    end
                end
                PH_HIGH: begin
                    if (c == CH_NUL) begin
                        res[n++] = make_result(KIND_ERROR, 8'h00, pair_pos);
                        restart();
                    end else begin
                        low_ch   = c;
                        phase    = PH_LOW;
                        char_pos = bump(char_pos);
                    end
                end
                PH_LOW: begin
                    hv = nibble_of(high_ch);
                    lv = nibble_of(low_ch);
                    if ((c == CH_SP || c == CH_CR || c == CH_NUL) && !hv[4] && !lv[4]) begin
                        res[n++]   = make_result(KIND_BYTE, {hv[3:0], lv[3:0]}, 16'd0);
                        byte_total = bump(byte_total);
                        if (c == CH_NUL) begin
                            res[n++] = make_result(KIND_DONE, 8'h00, byte_total);
                            restart();
                        end else begin
                            phase    = (c == CH_SP) ? PH_AFTER_SP : PH_AFTER_CR;
                            char_pos = bump(char_pos);
                        end
                    end else begin
                        res[n++] = make_result(KIND_ERROR, 8'h00, pair_pos);
                        if (c == CH_NUL) begin
                            restart();
                        end else begin
                            phase    = PH_DROP;
                            char_pos = bump(char_pos);
                        end
                    end
                end
                default: begin
                    // drop until the string end
                    if (c == CH_NUL) restart();
                    else char_pos = bump(char_pos);
                end
            endcase
            for (int i = 0; i < n; i++) begin
                if (i == n - 1) res[i].last = 1'b1;
                awaited.push_back(res[i]);
            end
        endfunction

        function void match_result(input t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                $error("unexpected result: kind %0d byte_value %0h number %0d last %0b",
                       got.kind, got.byte_value, got.number, got.last);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.byte_value !== want.byte_value) begin
                $error("byte_value: expected %0h, actual %0h", want.byte_value,
                       got.byte_value);
                errors++;
            end
            if (got.number !== want.number) begin
                $error("number: expected %0d, actual %0d", want.number, got.number);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_code;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [15:0] number;
    logic        last;

    hex_parse_checker board;
    bit               tx_idle_on;
    bit               rx_idle_on;
    bit               hold_req;
    int               idle_cycles;
    int               sent;

    hex_text_to_bytes_parser_unit u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_char_code  (char_code),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_kind       (kind),
        .o_byte_value (byte_value),
        .o_number     (number),
        .o_last       (last)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin : monitor
        t_result got;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got.kind       = t_kind'(kind);
                got.byte_value = byte_value;
                got.number     = number;
                got.last       = last;
                board.match_result(got);
            end
            if (in_valid && in_ready) board.take_char(char_code);
            if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin : rx_drive
        out_ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                // hold off long enough for the block to fill and stall its input
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    task automatic send_char(input logic [7:0] c);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    function automatic logic [7:0] rand_hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(0, 15));
        if (v < 4'd10) return 8'h30 + {4'd0, v};
        return (($urandom_range(0, 1) == 1) ? 8'h61 : 8'h41) + {4'd0, v} - 8'd10;
    endfunction

    task automatic send_random_string();
        logic [7:0] txt[$];
        int         pairs;
        int         style;
        int         idx;
        pairs = $urandom_range(0, 6);
        style = $urandom_range(0, 9);
        if (style == 9) begin
            // noise: arbitrary bytes, stray string ends included
            repeat ($urandom_range(1, 24)) txt.push_back(8'($urandom_range(0, 255)));
        end else begin
            for (int k = 0; k < pairs; k++) begin
                txt.push_back(rand_hex_char());
                txt.push_back(rand_hex_char());
                // the last pair may be closed by the string end alone
                if (k < pairs - 1 || $urandom_range(0, 2) != 0) begin
                    if ($urandom_range(0, 1) == 1) begin
                        txt.push_back(CH_SP);
                        if ($urandom_range(0, 1) == 1) txt.push_back(CH_CR);
                        if ($urandom_range(0, 1) == 1) txt.push_back(CH_LF);
                    end else begin
                        txt.push_back(CH_CR);
                        if ($urandom_range(0, 1) == 1) txt.push_back(CH_LF);
                    end
                end
            end
            if (style == 6) txt.push_back(rand_hex_char());
            // break one character: bad digit, bad separator or an early string end
            if (style >= 7 && txt.size() > 0) begin
                idx      = $urandom_range(0, txt.size() - 1);
                txt[idx] = 8'($urandom_range(0, 255));
            end
        end
        txt.push_back(CH_NUL);
        foreach (txt[i]) send_char(txt[i]);
    endtask

    initial begin : stimulus
        int start;
        board      = new();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_req   = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        char_code <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // lowercase, CR LF skip, pair closed by the string end
        send_text("a0\r\nFF");
        send_char(CH_NUL);
        // bad digit with a good separator, string end while dropping
        send_text("9g x");
        send_char(CH_NUL);
        // bad separator, top character code
        send_text("12");
        send_char(8'hFF);
        send_char(CH_NUL);
        // lone digit, then error with the string end as third character
        send_text("3");
        send_char(CH_NUL);
        send_text("zz");
        send_char(CH_NUL);
        // empty string, then space CR LF skip
        send_char(CH_NUL);
        send_text("00 \r\n");
        send_char(CH_NUL);

        hold_req = 1'b1;
        start = sent;
        while (sent - start < 60) send_random_string();

        start = sent;
        while (sent - start < 520) send_random_string();

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        start = sent;
        while (sent - start < 130) send_random_string();
        in_valid <= 1'b0;

        while (board.awaited.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.awaited.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/htb_pkg.sv
sv/htb_core.sv
sv/htb_out_fifo.sv
sv/hex_text_to_bytes_parser_unit.sv
tb/tb.sv
